>>> src/segment_tree_range_sum_unit_macros.svh
// Assertion macros for the segment tree range sum unit and its checker.
// Needs signals named clk and rst in the scope that uses them.
`ifndef SEGMENT_TREE_RANGE_SUM_UNIT_MACROS_SVH
`define SEGMENT_TREE_RANGE_SUM_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STSUM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STSUM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/stsum_pkg.sv
// Shared types and constants of the segment tree range sum unit.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package stsum_pkg;

  localparam int MAX_ELEMENTS_DEFAULT = 1024;
  localparam int COUNT_RESET          = 1024;
  localparam int VALUE_W              = 32;
  localparam int INDEX_W              = 10;
  localparam int COUNT_W              = 11;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UP_READ,
    S_UP_ADD,
    S_Q_LEVEL,
    S_Q_SECOND,
    S_Q_ACC,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> src/stsum_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module stsum_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/segment_tree_range_sum_unit.sv
// Top level of the segment tree range sum unit: sequencer, shared adder, tree RAM.
// Depends on stsum_pkg and stsum_ram.
`default_nettype none

// This unit keeps a binary sum tree over up to MAX_ELEMENTS signed 32-bit
// elements in one RAM of 2*MAX_ELEMENTS words; leaf i lives at word
// MAX_ELEMENTS+i and every inner word holds the sum of its two children.
// An update beat (operation 0) writes one leaf and then walks up to the
// root, and a query beat (operation 1) returns the wrapped sum of elements
// range_low..range_high, with range_high clipped to the active count and an
// empty range giving 0. An update whose position is not below the active
// count writes nothing and returns status 1. The active count is the
// element_count register, limited to MAX_ELEMENTS, written through
// cfg_write_en/cfg_write_data; the user is to write it only while the unit
// is idle, and the unit does not enforce this. After reset a clearing pass
// zeroes the tree with in_ready low; configuration writes are taken during
// it. The unit works on one beat at a time. An update writes the leaf and
// then, for each tree level, reads the sibling and writes the new sum to
// the parent. A query reads the two boundary nodes of each level it visits
// and adds those inside the range. This sequencing follows from the single
// read port of the tree RAM, whose read data arrives in the cycle after the
// address, and from the one 32-bit adder that every level shares. Each beat
// gives exactly one result beat, held in an output register, so the next
// input beat is taken while the previous result still waits for out_ready.
module segment_tree_range_sum_unit #(
  parameter int MaxElements = stsum_pkg::MAX_ELEMENTS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_en,
  input  wire logic        [stsum_pkg::COUNT_W-1:0] cfg_write_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 operation,
  input  wire logic        [stsum_pkg::INDEX_W-1:0] position,
  input  wire logic signed [stsum_pkg::VALUE_W-1:0] value,
  input  wire logic        [stsum_pkg::INDEX_W-1:0] range_low,
  input  wire logic        [stsum_pkg::INDEX_W-1:0] range_high,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed      [stsum_pkg::VALUE_W-1:0] range_sum,
  output logic                                      status
);

  localparam int Depth = 2 * MaxElements;
  localparam int AddrW = $clog2(Depth);
  localparam int SpanW = AddrW + 1;
  localparam int CntW  = $clog2(MaxElements + 1);
  localparam int VW    = stsum_pkg::VALUE_W;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0] RootAddr = AddrW'(1);

  stsum_pkg::state_t state, state_next;

  logic [stsum_pkg::COUNT_W-1:0] element_count;
  logic [AddrW-1:0]              clr_addr;
  logic [AddrW-1:0]              node;
  logic [VW-1:0]                 acc;
  logic [SpanW-1:0]              qa;
  logic [SpanW-1:0]              qb;
  logic                          item_op;
  logic                          item_status;

  // Decoded view of the beat on the input ports.
  logic [CntW-1:0]  active_cnt;
  logic [31:0]      hi_clip;
  logic             pos_ok;
  logic             query_empty;
  logic [AddrW-1:0] leaf_addr;
  logic [SpanW-1:0] qa_start;
  logic [SpanW-1:0] qb_start;

  // RAM control and the shared adder.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [VW-1:0]    ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [VW-1:0]    ram_rdata;
  logic [VW-1:0]    add_out;
  logic             acc_add;
  logic [SpanW-1:0] qb_dec;

  logic start;
  logic load_out;

  assign start    = (state == stsum_pkg::S_IDLE) && in_valid;
  assign load_out = (state == stsum_pkg::S_DONE) && (!out_valid || out_ready);
  assign in_ready = (state == stsum_pkg::S_IDLE);
  assign add_out  = acc + ram_rdata;
  assign qb_dec   = qb - SpanW'(1);

  // A count register above the tree size acts as the tree size.
  always_comb begin
    if (32'(element_count) > 32'(MaxElements)) begin
      active_cnt = CntW'(MaxElements);
    end else begin
      active_cnt = CntW'(element_count);
    end
  end

  always_comb begin
    pos_ok    = 32'(position) < 32'(active_cnt);
    leaf_addr = AddrW'(MaxElements) + AddrW'(position);
    if (32'(range_high) >= 32'(active_cnt)) begin
      hi_clip = 32'(active_cnt) - 32'd1;
    end else begin
      hi_clip = 32'(range_high);
    end
    query_empty = (active_cnt == '0) || (32'(range_low) > hi_clip);
    qa_start    = SpanW'(MaxElements) + SpanW'(range_low);
    qb_start    = SpanW'(32'(MaxElements) + hi_clip + 32'd1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      stsum_pkg::S_CLEAR: begin
        if (clr_addr == LastAddr) begin
          state_next = stsum_pkg::S_IDLE;
        end
      end
      stsum_pkg::S_IDLE: begin
        if (in_valid) begin
          if (operation == stsum_pkg::OP_UPDATE) begin
            state_next = pos_ok ? stsum_pkg::S_UP_READ : stsum_pkg::S_DONE;
          end else begin
            state_next = query_empty ? stsum_pkg::S_DONE : stsum_pkg::S_Q_LEVEL;
          end
        end
      end
      stsum_pkg::S_UP_READ: begin
        state_next = (node == RootAddr) ? stsum_pkg::S_DONE : stsum_pkg::S_UP_ADD;
      end
      stsum_pkg::S_UP_ADD:   state_next = stsum_pkg::S_UP_READ;
      stsum_pkg::S_Q_LEVEL: begin
        state_next = (qa >= qb) ? stsum_pkg::S_DONE : stsum_pkg::S_Q_SECOND;
      end
      stsum_pkg::S_Q_SECOND: state_next = stsum_pkg::S_Q_ACC;
      stsum_pkg::S_Q_ACC:    state_next = stsum_pkg::S_Q_LEVEL;
      stsum_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = stsum_pkg::S_IDLE;
        end
      end
      default: state_next = stsum_pkg::S_CLEAR;
    endcase
  end

  // RAM addressing and adder use for each state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = '0;
    ram_raddr = node ^ RootAddr;
    acc_add   = 1'b0;
    unique case (state)
      stsum_pkg::S_CLEAR: begin
        ram_we = 1'b1;
      end
      stsum_pkg::S_IDLE: begin
        ram_we    = start && (operation == stsum_pkg::OP_UPDATE) && pos_ok;
        ram_waddr = leaf_addr;
        ram_wdata = $unsigned(value);
      end
      stsum_pkg::S_UP_READ: begin
        ram_raddr = node ^ RootAddr;
      end
      stsum_pkg::S_UP_ADD: begin
        // The sibling is now on the read port; the parent gets the new sum.
        ram_we    = 1'b1;
        ram_waddr = node >> 1;
        ram_wdata = add_out;
        acc_add   = 1'b1;
      end
      stsum_pkg::S_Q_LEVEL: begin
        ram_raddr = qa[AddrW-1:0];
      end
      stsum_pkg::S_Q_SECOND: begin
        ram_raddr = qb_dec[AddrW-1:0];
        acc_add   = qa[0];
      end
      stsum_pkg::S_Q_ACC: begin
        acc_add = qb[0];
      end
      stsum_pkg::S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= stsum_pkg::S_CLEAR;
      clr_addr      <= '0;
      element_count <= stsum_pkg::COUNT_W'(stsum_pkg::COUNT_RESET);
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        element_count <= cfg_write_data;
      end
      if (state == stsum_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + AddrW'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; they carry no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      item_op     <= operation;
      item_status <= (operation == stsum_pkg::OP_UPDATE && !pos_ok) ?
                     stsum_pkg::STATUS_IGNORED : stsum_pkg::STATUS_DONE;
      node        <= leaf_addr;
      acc         <= (operation == stsum_pkg::OP_UPDATE) ? $unsigned(value) : '0;
      qa          <= qa_start;
      qb          <= qb_start;
    end else begin
      if (acc_add) begin
        acc <= add_out;
      end
      if (state == stsum_pkg::S_UP_ADD) begin
        node <= node >> 1;
      end
      if (state == stsum_pkg::S_Q_ACC) begin
        qa <= (qa + SpanW'(qa[0])) >> 1;
        qb <= (qb - SpanW'(qb[0])) >> 1;
      end
    end
    if (load_out) begin
      range_sum <= (item_op == stsum_pkg::OP_QUERY) ? $signed(acc) : '0;
      status    <= item_status;
    end
  end

  stsum_ram #(
    .Width (VW),
    .Depth (Depth)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

>>> src/stsum_checker.sv
// Port-level checker for the segment tree range sum unit, bound to the top level.
// Depends on stsum_pkg and segment_tree_range_sum_unit_macros.svh.
`default_nettype none

`include "segment_tree_range_sum_unit_macros.svh"

module stsum_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 in_valid,
  input wire logic                                 in_ready,
  input wire logic                                 out_valid,
  input wire logic                                 out_ready,
  input wire logic signed [stsum_pkg::VALUE_W-1:0] range_sum,
  input wire logic                                 status
);

  // An ignored update never carries a sum.
  `STSUM_ASSERT_SAME(a_ignored_sum_zero, out_valid && (status == stsum_pkg::STATUS_IGNORED), range_sum == '0, "ignored update returned a nonzero sum")

  // One beat at a time: the unit is busy right after it takes a beat.
  `STSUM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while a beat is in flight")

  // The clearing pass holds off input right after reset.
  `STSUM_ASSERT_SAME(a_clear_after_reset, $fell(rst), !in_ready, "input ready before the tree was cleared")

  // A stalled result stays put.
  `STSUM_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(range_sum) && $stable(status), "result changed while stalled")

endmodule

bind segment_tree_range_sum_unit stsum_checker u_stsum_checker (.*);

`default_nettype wire
